// File: design/pms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_pkg: shared types and constants for the pattern match stream core
// Beat payloads, register indexes and the control word handed to each cell.
// ----------------------------------------------------------------------------
package pms_pkg;

  // sizes
  localparam int MaxPattern = 16;
  localparam int MaxText    = 4096;
  localparam int ByteW      = 8;
  localparam int LenW       = 5;
  localparam int OffsetW    = 12;
  localparam int CfgDataW   = 64;
  localparam int CfgIdxW    = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegPatLow  = 2'd0,
    RegPatHigh = 2'd1,
    RegPatLen  = 2'd2
  } pms_reg_e;

  // input beat
  typedef struct packed {
    logic [ByteW-1:0] text_byte;
    logic             text_start;
  } pms_in_t;

  // output beat
  typedef struct packed {
    logic               match_found;
    logic [OffsetW-1:0] match_start;
  } pms_out_t;

  // per-cell control word
  typedef struct packed {
    logic             shift;
    logic             clear;
    logic             in_use;
    logic [ByteW-1:0] exp_byte;
  } pms_cell_ctrl_t;

endpackage

// File: design/pms_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pms_cell: one history cell of the matcher chain
// Holds one text byte and its valid bit, takes its neighbor's byte on every
// accepted beat and compares the new byte with its expected pattern byte.
// ----------------------------------------------------------------------------
module pms_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pms_pkg::pms_cell_ctrl_t      ctrl_i,
  input  logic [pms_pkg::ByteW-1:0]    byte_i,
  input  logic                         valid_i,
  output logic [pms_pkg::ByteW-1:0]    byte_o,
  output logic                         valid_o,
  output logic                         hit_o
);

  logic [pms_pkg::ByteW-1:0] byte_q, byte_d;
  logic                      valid_q, valid_d;

  // next contents: neighbor's byte, or empty on a new text
  always_comb begin
    byte_d  = byte_i;
    valid_d = valid_i & ~ctrl_i.clear;
  end

  // history byte, no reset needed since valid gates it
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      byte_q <= byte_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= valid_d;
    end
  end

  // cell beyond the pattern length always agrees
  assign hit_o   = ~ctrl_i.in_use | (valid_d & (byte_d == ctrl_i.exp_byte));
  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

// File: design/pattern_match_stream_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_match_stream_core: streaming single-pattern byte matcher
// Reports every occurrence, overlaps included, of a 1 to 16 byte pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one text byte
//   per beat; text_start marks the first byte of a new text and clears the
//   byte history and the offset counter before that byte is taken.
//   Output channel (out_valid_o / out_stall_i / out_data_o) carries one beat
//   per input beat: match_found is set when the pattern ends at that byte and
//   match_start gives the offset of its first byte (zero otherwise).
//   The offset counter saturates at 4095.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (pattern bytes 0-7, pattern bytes 8-15, pattern length); write only
//   while no beat is in flight.
// Timing and throughput:
//   The output beat appears in the cycle after its input beat is accepted;
//   one byte per cycle while the receiver does not stall. The 16 history
//   cells shift and compare in the same cycle, ahead of one output register.
// Reset and stalls:
//   Reset empties the history, clears the offset and the pattern registers
//   (length 1). While the receiver stalls a held output beat, in_stall_o is
//   raised and the held beat stays unchanged.
// ----------------------------------------------------------------------------
module pattern_match_stream_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pms_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [pms_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  pms_pkg::pms_in_t                 in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output pms_pkg::pms_out_t                out_data_o
);

  localparam int NCell = pms_pkg::MaxPattern;
  localparam int PatIdxW = $clog2(pms_pkg::MaxPattern);
  localparam logic [pms_pkg::OffsetW-1:0] OffsetTop =
    pms_pkg::OffsetW'(pms_pkg::MaxText - 1);

  // configuration registers
  logic [pms_pkg::CfgDataW-1:0] pat_low_q, pat_high_q;
  logic [pms_pkg::LenW-1:0]     pat_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= pms_pkg::LenW'(1);
    end else if (cfg_we_i) begin
      case (pms_pkg::pms_reg_e'(cfg_idx_i))
        pms_pkg::RegPatLow:  pat_low_q  <= cfg_wdata_i;
        pms_pkg::RegPatHigh: pat_high_q <= cfg_wdata_i;
        pms_pkg::RegPatLen:  pat_len_q  <= cfg_wdata_i[pms_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // active length clamped to 1..16
  logic [pms_pkg::LenW-1:0] len_act;
  always_comb begin
    if (pat_len_q == '0) begin
      len_act = pms_pkg::LenW'(1);
    end else if (pat_len_q > pms_pkg::LenW'(pms_pkg::MaxPattern)) begin
      len_act = pms_pkg::LenW'(pms_pkg::MaxPattern);
    end else begin
      len_act = pat_len_q;
    end
  end

  // pattern bytes as an array
  logic [2*pms_pkg::CfgDataW-1:0] pat_all;
  logic [pms_pkg::ByteW-1:0]      pat_byte [NCell];
  assign pat_all = {pat_high_q, pat_low_q};
  always_comb begin
    for (int k = 0; k < NCell; k++) begin
      pat_byte[k] = pat_all[pms_pkg::ByteW*k +: pms_pkg::ByteW];
    end
  end

  // handshake
  logic accept;
  logic out_valid_q;
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // cell control words: cell i holds the byte i places back
  pms_pkg::pms_cell_ctrl_t cell_ctrl [NCell];
  always_comb begin
    logic [pms_pkg::LenW-1:0] sel;
    for (int i = 0; i < NCell; i++) begin
      sel = len_act - pms_pkg::LenW'(i) - pms_pkg::LenW'(1);
      cell_ctrl[i].shift    = accept;
      cell_ctrl[i].clear    = (i != 0) & in_data_i.text_start;
      cell_ctrl[i].in_use   = pms_pkg::LenW'(i) < len_act;
      cell_ctrl[i].exp_byte = pat_byte[sel[PatIdxW-1:0]];
    end
  end

  // chain of cells
  logic [pms_pkg::ByteW-1:0] cell_byte [NCell];
  logic [NCell-1:0]          cell_valid;
  logic [NCell-1:0]          cell_hit;

  for (genvar i = 0; i < NCell; i++) begin : g_cell
    logic [pms_pkg::ByteW-1:0] nb_byte;
    logic                      nb_valid;
    if (i == 0) begin : g_head
      assign nb_byte  = in_data_i.text_byte;
      assign nb_valid = 1'b1;
    end else begin : g_body
      assign nb_byte  = cell_byte[i-1];
      assign nb_valid = cell_valid[i-1];
    end
    pms_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl[i]),
      .byte_i  (nb_byte),
      .valid_i (nb_valid),
      .byte_o  (cell_byte[i]),
      .valid_o (cell_valid[i]),
      .hit_o   (cell_hit[i])
    );
  end

  // offset of this byte and of the next
  logic [pms_pkg::OffsetW-1:0] offset_q, offset_d, pos;
  logic [pms_pkg::OffsetW:0]   pos_inc;
  assign pos      = in_data_i.text_start ? '0 : offset_q;
  assign pos_inc  = {1'b0, pos} + (pms_pkg::OffsetW+1)'(1);
  assign offset_d = (pos == OffsetTop) ? OffsetTop : pos_inc[pms_pkg::OffsetW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else if (accept) begin
      offset_q <= offset_d;
    end
  end

  // match result for this byte
  pms_pkg::pms_out_t res;
  logic [pms_pkg::OffsetW:0] start_w;
  logic                      found;
  assign start_w = pos_inc - (pms_pkg::OffsetW+1)'(len_act);
  assign found   = (&cell_hit) & (pos_inc >= (pms_pkg::OffsetW+1)'(len_act));
  always_comb begin
    res.match_found = found;
    res.match_start = found ? start_w[pms_pkg::OffsetW-1:0] : '0;
  end

  // output register
  pms_pkg::pms_out_t out_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: tb/tb_pattern_match_stream_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pattern_match_stream_core: self-checking bench for the pattern matcher
// Streams text beats through the core, predicts each match beat from a local
// copy of the byte history, offset counter and pattern registers, and checks
// every output beat in order. Covers directed corner cases and random texts
// under varied idling.
// ----------------------------------------------------------------------------
module tb_pattern_match_stream_core;

  localparam int LongHold    = 300;
  localparam int DrainCycles = 3;
  localparam int CycleLimit  = 500000;

  // dut ports
  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         cfg_we_i    = 1'b0;
  logic [pms_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [pms_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  pms_pkg::pms_in_t             in_data_i   = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  pms_pkg::pms_out_t            out_data_o;

  // stimulus and checking state
  pms_pkg::pms_in_t  pending_bytes[$];
  pms_pkg::pms_out_t expected_matches[$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  logic        hold_req     = 1'b0;
  logic        hold_ack     = 1'b0;
  int unsigned hold_left    = 0;

  // local copy of the matcher state and registers
  logic [7:0]  hist_bytes [pms_pkg::MaxPattern] = '{default: '0};
  int unsigned seen_cnt  = 0;
  int unsigned text_pos  = 0;
  logic [63:0] pat_lo_m  = '0;
  logic [63:0] pat_hi_m  = '0;
  logic [4:0]  pat_len_m = 5'd1;

  pattern_match_stream_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // match prediction for one text beat, advancing the local state
  function automatic pms_pkg::pms_out_t predict_match(pms_pkg::pms_in_t beat);
    int unsigned       len, pos, i, k;
    logic              hit;
    logic [7:0]        pb;
    pms_pkg::pms_out_t res;
    len = (pat_len_m == 0) ? 1 : pat_len_m;
    if (len > pms_pkg::MaxPattern) len = pms_pkg::MaxPattern;
    if (beat.text_start) begin
      for (i = 0; i < pms_pkg::MaxPattern; i++) hist_bytes[i] = '0;
      seen_cnt = 0;
      text_pos = 0;
    end
    pos = text_pos;
    for (i = pms_pkg::MaxPattern - 1; i > 0; i--) hist_bytes[i] = hist_bytes[i-1];
    hist_bytes[0] = beat.text_byte;
    if (seen_cnt < pms_pkg::MaxPattern) seen_cnt++;
    hit = (seen_cnt >= len);
    for (k = 0; k < len; k++) begin
      pb = (k < 8) ? pat_lo_m[8*k +: 8] : pat_hi_m[8*(k-8) +: 8];
      if (hist_bytes[len-1-k] != pb) hit = 1'b0;
    end
    res = '0;
    if (hit && (pos + 1 >= len)) begin
      res.match_found = 1'b1;
      res.match_start = pms_pkg::OffsetW'(pos + 1 - len);
    end
    text_pos = (pos + 1 < pms_pkg::MaxText) ? pos + 1 : pms_pkg::MaxText - 1;
    return res;
  endfunction

  task automatic flag_mismatch(string what, pms_pkg::pms_out_t want,
                               pms_pkg::pms_out_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch (%s): expected found=%0b start=%0d, got found=%0b start=%0d",
               what, want.match_found, want.match_start, got.match_found, got.match_start);
  endtask

  // text beat driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_bytes.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack    <= hold_req;
      hold_left   <= LongHold;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // monitor: predict on accepted text beats, check accepted result beats
  always @(posedge clk_i) begin : mon
    pms_pkg::pms_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_matches.push_back(predict_match(in_data_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_matches.size() == 0) begin
          flag_mismatch("no beat expected", '0, out_data_o);
        end else begin
          want = expected_matches.pop_front();
          if (out_data_o.match_found !== want.match_found ||
              out_data_o.match_start !== want.match_start)
            flag_mismatch("field", want, out_data_o);
        end
      end
    end
  end

  // register write, mirrored locally
  task automatic write_reg(pms_pkg::pms_reg_e idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      pms_pkg::RegPatLow:  pat_lo_m  = val;
      pms_pkg::RegPatHigh: pat_hi_m  = val;
      pms_pkg::RegPatLen:  pat_len_m = val[4:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_idling(int unsigned tx_pct, int unsigned rx_pct);
    @(posedge clk_i);
    tx_idle_pct <= tx_pct;
    rx_idle_pct <= rx_pct;
    @(negedge clk_i);
  endtask

  task automatic add_byte(logic [7:0] b, logic s);
    pending_bytes.push_back(pms_pkg::pms_in_t'{text_byte: b, text_start: s});
  endtask

  // sender runs dry and every result comes back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || expected_matches.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // random pattern over a two-byte alphabet, text built from pattern copies,
  // broken prefixes, alphabet filler and noise
  task automatic run_random_phase(int n_items);
    logic [7:0]  alph [2];
    logic [7:0]  pat_b [pms_pkg::MaxPattern];
    logic [63:0] lo, hi;
    logic [4:0]  len_code;
    int unsigned len, r, copy_n;
    int          left, k;
    logic        fresh;
    alph[0] = 8'($urandom);
    alph[1] = 8'($urandom);
    r = $urandom_range(0, 19);
    if (r == 0) len_code = 5'($urandom_range(0, 31));
    else if (r < 3) len_code = 5'($urandom_range(7, 16));
    else len_code = 5'($urandom_range(1, 6));
    len = (len_code == 0) ? 1 : len_code;
    if (len > pms_pkg::MaxPattern) len = pms_pkg::MaxPattern;
    for (k = 0; k < pms_pkg::MaxPattern; k++)
      pat_b[k] = (k < len) ? alph[$urandom_range(0, 1)] : 8'($urandom);
    for (k = 0; k < 8; k++) begin
      lo[8*k +: 8] = pat_b[k];
      hi[8*k +: 8] = pat_b[k+8];
    end
    write_reg(pms_pkg::RegPatLow, lo);
    write_reg(pms_pkg::RegPatHigh, hi);
    write_reg(pms_pkg::RegPatLen, 64'(len_code));
    left = n_items;
    while (left > 0) begin
      r     = $urandom_range(0, 99);
      fresh = ($urandom_range(0, 39) == 0);
      if (r < 30) begin
        copy_n = (r < 20) ? len : $urandom_range(1, len);
        for (k = 0; k < copy_n && left > 0; k++) begin
          add_byte(pat_b[k], fresh && k == 0);
          left--;
        end
      end else if (r < 90) begin
        add_byte(alph[$urandom_range(0, 1)], fresh);
        left--;
      end else begin
        add_byte(8'($urandom), fresh);
        left--;
      end
    end
  endtask

  // main sequence
  initial begin : seq
    int k, mode, ph;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_idling(19, 74);

    // reset registers: single zero byte pattern
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    wait_drained();

    // length zero acts as one
    write_reg(pms_pkg::RegPatLow, '1);
    write_reg(pms_pkg::RegPatLen, 64'd0);
    add_byte(8'hFF, 1'b1);
    add_byte(8'hFF, 1'b0);
    wait_drained();

    // oversized length acts as the full sixteen bytes
    write_reg(pms_pkg::RegPatLow, 64'h00FF_00FF_00FF_00FF);
    write_reg(pms_pkg::RegPatHigh, 64'h00FF_00FF_00FF_00FF);
    write_reg(pms_pkg::RegPatLen, 64'd31);
    for (k = 0; k < pms_pkg::MaxPattern; k++)
      add_byte((k % 2 == 0) ? 8'hFF : 8'h00, k == 0);
    wait_drained();

    // overlapping matches, then a new text breaks the run
    write_reg(pms_pkg::RegPatLow, 64'hDEAD_BEEF_1234_4141);
    write_reg(pms_pkg::RegPatLen, 64'd2);
    add_byte(8'h41, 1'b1);
    add_byte(8'h41, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h41, 1'b1);
    wait_drained();

    // random texts under three idling mixes
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: set_idling(19, 74);
        1: set_idling(74, 19);
        default: set_idling(0, 0);
      endcase
      for (ph = 0; ph < 4; ph++) begin
        run_random_phase(110);
        if (mode == 2 && ph == 0) begin
          @(posedge clk_i);
          hold_req <= ~hold_req;
          @(negedge clk_i);
        end
        wait_drained();
      end
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
